@@ design/iostk_pkg.sv @@
// ----------------------------------------------------------------------------
// iostk_pkg
// Shared types and constants of the indexed object stack.
// ----------------------------------------------------------------------------
package iostk_pkg;

  localparam int DATA_W              = 64;
  localparam int IDX_W               = 10;
  localparam int STACK_DEPTH_DEFAULT = 1024;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_POKE  = 3'd3,
    ACT_BOT   = 3'd4,
    ACT_COUNT = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

endpackage

@@ design/iostk_req_if.sv @@
// ----------------------------------------------------------------------------
// iostk_req_if
// Request channel of the indexed object stack: one action per transfer.
// ----------------------------------------------------------------------------
interface iostk_req_if;
  import iostk_pkg::*;

  logic                      valid;
  logic                      ready;
  action_t                   action;
  logic [IDX_W-1:0]          index;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, output action, output index, output value, input ready);
  modport sink   (input valid, input action, input index, input value, output ready);

endinterface

@@ design/iostk_rsp_if.sv @@
// ----------------------------------------------------------------------------
// iostk_rsp_if
// Response channel of the indexed object stack: one result per transfer.
// ----------------------------------------------------------------------------
interface iostk_rsp_if #(
  parameter int FILL_W = 11
);
  import iostk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  data_out;
  logic [FILL_W-1:0]         fill;
  status_t                   status;

  modport source (output valid, output data_out, output fill, output status, input ready);
  modport sink   (input valid, input data_out, input fill, input status, output ready);

endinterface

@@ design/iostk_ram.sv @@
// ----------------------------------------------------------------------------
// iostk_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module iostk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/indexed_object_stack_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_object_stack_unit
// Last-in first-out store of 64-bit objects with push, pop, peek and poke
// below the top, read above the bottom, and a fill count.
// ----------------------------------------------------------------------------
//  channel  dir  payload                      transfer when
//  req      in   action, index, value         req.valid && req.ready
//  rsp      out  data_out, fill, status       rsp.valid && rsp.ready
//
// One action is accepted per cycle while the response is not stalled; its
// result appears in the next cycle, from the registered read of the entry
// RAM. The fill pointer is updated at the request transfer, so back-to-back
// actions see each other. Reset clears the fill pointer and the response
// valid; entries are not cleared. A stalled response holds the request
// side while the result register is full and not taken.
// ----------------------------------------------------------------------------
module indexed_object_stack_unit #(
  parameter int STACK_DEPTH = iostk_pkg::STACK_DEPTH_DEFAULT,
  parameter int FILL_W      = $clog2(STACK_DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  iostk_req_if.sink    req,
  iostk_rsp_if.source  rsp
);
  import iostk_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = FILL_W + IDX_W;

  logic [FILL_W-1:0] depth_used;
  logic [FILL_W-1:0] depth_used_next;
  logic              out_valid;
  logic [FILL_W-1:0] out_fill;
  status_t           out_status;
  logic              out_rd;

  logic              accept;
  status_t           status_next;
  logic              rd_next;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     depth_ext;
  logic [CW-1:0]     pos;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign idx_ext   = CW'(req.index);
  assign depth_ext = CW'(depth_used);
  assign pos       = depth_ext - CW'(1) - idx_ext;

  always_comb begin
    depth_used_next = depth_used;
    status_next     = ST_OK;
    rd_next         = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = depth_used[AW-1:0];
    ram_raddr       = pos[AW-1:0];
    case (req.action)
      ACT_PUSH: begin
        if (depth_used == FILL_W'(STACK_DEPTH)) begin
          status_next = ST_OVER;
        end else begin
          ram_we          = accept;
          depth_used_next = depth_used + FILL_W'(1);
        end
      end
      ACT_POP: begin
        ram_raddr = depth_used_next[AW-1:0];
        if (depth_used == '0) begin
          status_next = ST_UNDER;
        end else begin
          depth_used_next = depth_used - FILL_W'(1);
          ram_raddr       = depth_used_next[AW-1:0];
          ram_re          = accept;
          rd_next         = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (idx_ext >= depth_ext) begin
          status_next = ST_UNDER;
        end else begin
          ram_re  = accept;
          rd_next = 1'b1;
        end
      end
      ACT_POKE: begin
        ram_waddr = pos[AW-1:0];
        if (idx_ext >= depth_ext) begin
          status_next = ST_UNDER;
        end else begin
          ram_we = accept;
        end
      end
      ACT_BOT: begin
        ram_raddr = idx_ext[AW-1:0];
        if (idx_ext >= depth_ext) begin
          status_next = ST_UNDER;
        end else begin
          ram_re  = accept;
          rd_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  iostk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        depth_used <= depth_used_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_fill   <= depth_used_next;
      out_status <= status_next;
      out_rd     <= rd_next;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.fill     = out_fill;
  assign rsp.status   = out_status;
  assign rsp.data_out = out_rd ? ram_rdata : '0;

endmodule

@@ design/iostk_chk.sv @@
// ----------------------------------------------------------------------------
// iostk_chk
// Port-level checks of the indexed object stack, bound to the top level.
// ----------------------------------------------------------------------------
module iostk_chk #(
  parameter int STACK_DEPTH = iostk_pkg::STACK_DEPTH_DEFAULT,
  parameter int FILL_W      = $clog2(STACK_DEPTH + 1)
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [iostk_pkg::DATA_W-1:0] data_out,
  input logic [FILL_W-1:0]                   fill,
  input iostk_pkg::status_t                  status
);
  import iostk_pkg::*;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> fill <= FILL_W'(STACK_DEPTH))
    else $error("Fill exceeds the stack depth.");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_OVER |-> fill == FILL_W'(STACK_DEPTH))
    else $error("Overflow reported while the stack is not full.");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> data_out == '0)
    else $error("Data is not zero on an error result.");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("Request stalled while the result register is empty.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(fill))
    else $error("Stalled result changed.");

endmodule

bind indexed_object_stack_unit iostk_chk #(
  .STACK_DEPTH (STACK_DEPTH),
  .FILL_W      (FILL_W)
) u_iostk_chk (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .data_out  (rsp.data_out),
  .fill      (rsp.fill),
  .status    (rsp.status)
);

@@ test/indexed_object_stack_unit_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_object_stack_unit_tb
// Self-checking bench for the indexed object stack. A short directed
// sequence covers the empty and out-of-range cases and the value
// extremes. Random traffic then fills the stack to the top and works it
// there, with bursty requests and a response side that stalls in
// changing patterns. A scoreboard predicts every result and compares it,
// field by field, with what the block returns.
// ----------------------------------------------------------------------------
module indexed_object_stack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iostk_pkg::*;

  localparam int DEPTH       = STACK_DEPTH_DEFAULT;
  localparam int FILL_BITS   = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [FILL_BITS-1:0]     fill;
    status_t                  status;
  } stack_result_t;

  typedef enum {MODE_MIX, MODE_CLIMB} traffic_mode_t;

  class stack_scoreboard;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int unsigned              depth_held;
    stack_result_t            awaited [$];
    int unsigned              fails;
    int unsigned              shown;

    function void flag(string msg);
      fails++;
      if (shown < 10) begin
        shown++;
        $display("%s", msg);
      end
    endfunction

    function void note_request(action_t act, logic [IDX_W-1:0] idx,
                               logic signed [DATA_W-1:0] val);
      stack_result_t r;
      r.data   = '0;
      r.status = ST_OK;
      case (act)
        ACT_PUSH: begin
          if (depth_held >= DEPTH) begin
            r.status = ST_OVER;
          end else begin
            entries[depth_held] = val;
            depth_held++;
          end
        end
        ACT_POP: begin
          if (depth_held == 0) begin
            r.status = ST_UNDER;
          end else begin
            depth_held--;
            r.data = entries[depth_held];
          end
        end
        ACT_PEEK, ACT_POKE: begin
          if (idx >= depth_held) begin
            r.status = ST_UNDER;
          end else if (act == ACT_PEEK) begin
            r.data = entries[depth_held - 1 - idx];
          end else begin
            entries[depth_held - 1 - idx] = val;
          end
        end
        ACT_BOT: begin
          if (idx >= depth_held) begin
            r.status = ST_UNDER;
          end else begin
            r.data = entries[idx];
          end
        end
        default: begin
        end
      endcase
      r.fill = FILL_BITS'(depth_held);
      awaited.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data,
                               logic [FILL_BITS-1:0] fill, status_t status);
      stack_result_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: data %h fill %0d status %0d",
                       data, fill, status));
        return;
      end
      e = awaited.pop_front();
      if (e.data !== data || e.fill !== fill || e.status !== status) begin
        flag($sformatf({"result mismatch: expected data %h fill %0d status %0d, ",
                        "got data %h fill %0d status %0d"},
                       e.data, e.fill, e.status, data, fill, status));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  iostk_req_if                       req ();
  iostk_rsp_if #(.FILL_W(FILL_BITS)) rsp ();

  indexed_object_stack_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  stack_scoreboard sb = new();

  int unsigned burst_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_count = 0;
  int unsigned cycles      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        sb.check_result(rsp.data_out, rsp.fill, rsp.status);
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      stall_count++;
      case (stall_mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= 1'($urandom_range(0, 1));
        2:       rsp.ready <= (stall_count % 4 == 0);
        default: rsp.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_item(action_t act, logic [IDX_W-1:0] idx,
                           logic signed [DATA_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    req.valid  <= 1'b1;
    req.action <= act;
    req.index  <= idx;
    req.value  <= val;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(act, idx, val);
  endtask

  task automatic wait_for_results;
    req.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic random_item(traffic_mode_t mode);
    int unsigned              roll;
    int unsigned              held;
    action_t                  act;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    held = sb.depth_held;
    roll = $urandom_range(0, 99);
    if (mode == MODE_CLIMB) begin
      act = (roll < 96) ? ACT_PUSH : (roll < 97) ? ACT_PEEK :
            (roll < 98) ? ACT_POKE : (roll < 99) ? ACT_BOT  : ACT_COUNT;
    end else begin
      act = (roll < 30) ? ACT_PUSH : (roll < 55) ? ACT_POP :
            (roll < 70) ? ACT_PEEK : (roll < 80) ? ACT_POKE :
            (roll < 95) ? ACT_BOT  : ACT_COUNT;
    end
    roll = $urandom_range(0, 9);
    if (held != 0 && roll < 6) begin
      idx = IDX_W'($urandom_range(0, held - 1));
    end else if (roll < 7) begin
      idx = IDX_W'(held);
    end else if (roll < 8) begin
      idx = '1;
    end else if (roll < 9) begin
      idx = '0;
    end else begin
      idx = IDX_W'($urandom_range(0, DEPTH - 1));
    end
    case ($urandom_range(0, 15))
      0:       val = {1'b1, {(DATA_W-1){1'b0}}};
      1:       val = {1'b0, {(DATA_W-1){1'b1}}};
      2:       val = '0;
      3:       val = '1;
      default: val = {$urandom, $urandom};
    endcase
    send_item(act, idx, val);
  endtask

  initial begin
    rst        <= 1'b1;
    req.valid  <= 1'b0;
    req.action <= ACT_PUSH;
    req.index  <= '0;
    req.value  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty stack, then four extreme words, then out-of-range indexes.
    send_item(ACT_POP,   10'd0,    64'sd0);
    send_item(ACT_PEEK,  10'd0,    64'sd0);
    send_item(ACT_POKE,  10'd0,    64'sd5);
    send_item(ACT_BOT,   10'd0,    64'sd0);
    send_item(ACT_COUNT, 10'd0,    64'sd0);
    send_item(ACT_PUSH,  10'd1023, {1'b0, {(DATA_W-1){1'b1}}});
    send_item(ACT_PUSH,  10'd0,    {1'b1, {(DATA_W-1){1'b0}}});
    send_item(ACT_PUSH,  10'd0,    64'sd0);
    send_item(ACT_PUSH,  10'd0,    -64'sd1);
    send_item(ACT_PEEK,  10'd0,    64'sd0);
    send_item(ACT_PEEK,  10'd3,    64'sd0);
    send_item(ACT_PEEK,  10'd4,    64'sd0);
    send_item(ACT_PEEK,  10'd1023, 64'sd0);
    send_item(ACT_POKE,  10'd1,    64'h0123_4567_89ab_cdef);
    send_item(ACT_BOT,   10'd2,    64'sd0);
    send_item(ACT_BOT,   10'd0,    64'sd0);
    send_item(ACT_BOT,   10'd4,    64'sd0);
    send_item(ACT_BOT,   10'd1023, 64'sd0);
    send_item(ACT_POKE,  10'd4,    64'sd7);
    send_item(ACT_COUNT, 10'd1023, 64'sd0);
    repeat (4) send_item(ACT_POP, 10'd0, 64'sd0);
    send_item(ACT_POP,   10'd0,    64'sd0);
    wait_for_results;

    repeat (30) random_item(MODE_MIX);
    while (sb.depth_held < DEPTH) random_item(MODE_CLIMB);
    wait_for_results;
    repeat (20) random_item(MODE_CLIMB);
    repeat (30) random_item(MODE_MIX);

    wait_for_results;
    repeat (4) @(posedge clk);
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
